/* design/fsps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsps_pkg
// Types, constants and helpers shared by the filtered radius point search.
// ----------------------------------------------------------------------------
package fsps_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int COORD_WIDTH = 32;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = 6;
	localparam int IDX_W       = 5;
	localparam int CSHIFT      = 32 - COORD_WIDTH;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [15:0] MATCH_ANY = 16'hFFFF;

	typedef struct packed {
		logic              req_type;
		logic [4:0]        entry_index;
		logic signed [15:0] kind_value;
		logic signed [15:0] team_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic              use_location;
		logic signed [31:0] search_radius;
		logic signed [31:0] height_limit;
		logic [5:0]        max_count;
	} req_t;

	typedef struct packed {
		logic [4:0] flag_index;
		logic       index_valid;
		logic [5:0] hit_total;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [15:0] kind;
		logic [15:0] team;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} entry_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic issue;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		logic last_addr;
		logic scan_empty;
		logic pipe_busy;
	} status_t;

	// low COORD_WIDTH bits, sign-extended to 33 bits
	function automatic logic signed [32:0] coord_ext(input logic [31:0] v);
		logic signed [31:0] t;
		t = signed'(v << CSHIFT) >>> CSHIFT;
		return 33'(t);
	endfunction

endpackage

/* design/fsps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fsps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/fsps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsps_ctrl
// Sequencer: takes requests, steps the table scan and issues the final item.
// ----------------------------------------------------------------------------
module fsps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  fsps_pkg::status_t status,
	output logic              busy,
	output fsps_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == fsps_pkg::REQ_QUERY) begin
						cmd.capture = 1'b1;
						state_d     = status.scan_empty ? S_DRAIN : S_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (status.last_addr) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// every match has left the pipe, so the count is final
				if (!status.pipe_busy) begin
					cmd.emit_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/fsps_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsps_dp
// Datapath: point table, scan address, gate pipeline and result register.
// ----------------------------------------------------------------------------
module fsps_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fsps_pkg::req_t             request,
	input  fsps_pkg::cmd_t             cmd,
	input  logic                       cfg_we,
	input  logic [fsps_pkg::CNT_W-1:0] cfg_data,
	output fsps_pkg::status_t          status,
	output fsps_pkg::res_t             result,
	output logic                       strobe
);

	localparam int AW = fsps_pkg::ADDR_W;
	localparam int CW = fsps_pkg::CNT_W;

	// configuration and captured query
	logic [CW-1:0]      flag_count_q;
	logic [15:0]        kind_q;
	logic [15:0]        team_q;
	logic signed [32:0] px_q, py_q, pz_q;
	logic               use_loc_q;
	logic               rad_neg_q;
	logic [30:0]        rad_q;
	logic               hlim_pos_q;
	logic [31:0]        hlim_q;
	logic [CW-1:0]      maxc_q;
	logic [61:0]        r2_q;
	logic signed [32:0] rad_ext;
	logic signed [32:0] hlim_ext;

	logic [CW-1:0] scan_len;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] found_q;

	// table
	fsps_pkg::entry_t wentry;
	fsps_pkg::entry_t rentry;
	logic [$bits(fsps_pkg::entry_t)-1:0] rdata;
	logic ram_we;

	assign wentry.kind = request.kind_value;
	assign wentry.team = request.team_value;
	assign wentry.x    = request.pos_x;
	assign wentry.y    = request.pos_y;
	assign wentry.z    = request.pos_z;
	assign ram_we = cmd.load &&
		({1'b0, request.entry_index} < (fsps_pkg::IDX_W + 1)'(fsps_pkg::MAX_ENTRIES));
	assign rentry = rdata;

	assign rad_ext  = fsps_pkg::coord_ext(request.search_radius);
	assign hlim_ext = fsps_pkg::coord_ext(request.height_limit);

	fsps_ram #(
		.WIDTH ($bits(fsps_pkg::entry_t)),
		.DEPTH (fsps_pkg::MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(request.entry_index)),
		.wdata (wentry),
		.re    (cmd.issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign scan_len = (flag_count_q > CW'(fsps_pkg::MAX_ENTRIES))
		? CW'(fsps_pkg::MAX_ENTRIES) : flag_count_q;

	// pipeline
	logic          v_s1, v_s2, v_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic          kt_ok_s2, kt_ok_s3;
	logic [31:0]   adx_s2, ady_s2, adz_s2;
	logic [63:0]   sqx_s3, sqy_s3, sqz_s3;
	logic          hfail_s3;

	logic signed [32:0] ex, ey, ez;
	logic signed [32:0] dx_ab, dx_ba, dy_ab, dy_ba, dz_ab, dz_ba;
	logic               kt_ok;
	logic [65:0]        sum3;
	logic               far;
	logic               match;

	assign ex = fsps_pkg::coord_ext(rentry.x);
	assign ey = fsps_pkg::coord_ext(rentry.y);
	assign ez = fsps_pkg::coord_ext(rentry.z);
	// both orders in parallel, the sign of one picks the magnitude
	assign dx_ab = px_q - ex;
	assign dx_ba = ex - px_q;
	assign dy_ab = py_q - ey;
	assign dy_ba = ey - py_q;
	assign dz_ab = pz_q - ez;
	assign dz_ba = ez - pz_q;
	assign kt_ok = (kind_q == fsps_pkg::MATCH_ANY || kind_q == rentry.kind) &&
		(team_q == fsps_pkg::MATCH_ANY || team_q == rentry.team);

	assign sum3  = {2'b00, sqx_s3} + {2'b00, sqy_s3} + {2'b00, sqz_s3};
	assign far   = sum3 > {4'b0000, r2_q};
	assign match = kt_ok_s3 && (!use_loc_q || ((rad_neg_q || !far) && !hfail_s3));

	assign status.last_addr  = (CW'(addr_q) + CW'(1)) == scan_len;
	assign status.scan_empty = (scan_len == '0);
	assign status.pipe_busy  = v_s1 || v_s2 || v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_count_q <= '0;
			addr_q       <= '0;
			found_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			strobe       <= 1'b0;
		end else begin
			if (cfg_we) begin
				flag_count_q <= cfg_data;
			end
			if (cmd.capture) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + AW'(1);
			end
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			strobe <= 1'b0;
			if (cmd.capture) begin
				found_q <= '0;
			end else if (v_s3 && match && found_q < maxc_q) begin
				found_q <= found_q + CW'(1);
				strobe  <= 1'b1;
			end else if (cmd.emit_final) begin
				strobe <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q     <= request.kind_value;
			team_q     <= request.team_value;
			px_q       <= fsps_pkg::coord_ext(request.pos_x);
			py_q       <= fsps_pkg::coord_ext(request.pos_y);
			pz_q       <= fsps_pkg::coord_ext(request.pos_z);
			use_loc_q  <= request.use_location;
			rad_neg_q  <= rad_ext < 0;
			rad_q      <= rad_ext[30:0];
			hlim_pos_q <= hlim_ext > 0;
			hlim_q     <= hlim_ext[31:0];
			maxc_q     <= request.max_count;
		end
		r2_q <= rad_q * rad_q;

		idx_s1   <= addr_q;
		idx_s2   <= idx_s1;
		kt_ok_s2 <= kt_ok;
		adx_s2   <= dx_ab[32] ? dx_ba[31:0] : dx_ab[31:0];
		ady_s2   <= dy_ab[32] ? dy_ba[31:0] : dy_ab[31:0];
		adz_s2   <= dz_ab[32] ? dz_ba[31:0] : dz_ab[31:0];

		idx_s3   <= idx_s2;
		kt_ok_s3 <= kt_ok_s2;
		sqx_s3   <= adx_s2 * adx_s2;
		sqy_s3   <= ady_s2 * ady_s2;
		sqz_s3   <= adz_s2 * adz_s2;
		hfail_s3 <= hlim_pos_q && (adz_s2 > hlim_q);

		if (v_s3 && match && found_q < maxc_q) begin
			result.flag_index  <= 5'(idx_s3);
			result.index_valid <= 1'b1;
			result.hit_total   <= '0;
			result.last        <= 1'b0;
		end else if (cmd.emit_final) begin
			result.flag_index  <= '0;
			result.index_valid <= 1'b0;
			result.hit_total   <= found_q;
			result.last        <= 1'b1;
		end
	end

endmodule

/* design/filtered_radius_point_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_radius_point_search
// Marker table with kind, team, radius and height filtered query scan.
// ----------------------------------------------------------------------------
// a load leaves busy low
// a query holds busy through its scan and drain; an empty scan holds it for the drain only
// one table entry enters the gate pipeline per cycle from the single RAM read port
// index items pass RAM read, s2, s3 and result registers; count item as busy goes low again
// reset clears control and flag_count; table contents stay undefined until loaded
// results are strobed for one cycle each, the receiver cannot stall
module filtered_radius_point_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  fsps_pkg::req_t             request,
	output fsps_pkg::res_t             result,
	output logic                       strobe,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fsps_pkg::CNT_W-1:0] cfg_data
);

	fsps_pkg::cmd_t    cmd;
	fsps_pkg::status_t status;

	assign cfg_ready = 1'b1;

	fsps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (request.req_type),
		.status   (status),
		.busy     (busy),
		.cmd      (cmd)
	);

	fsps_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cmd      (cmd),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.status   (status),
		.result   (result),
		.strobe   (strobe)
	);

	// a query ends exactly with its final count transfer
	a_end_final: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last)
		else $error("busy dropped without a final item");

	// index items only while a query is running
	a_index_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.index_valid |-> busy)
		else $error("index item outside a query");

	// an accepted query raises busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.req_type == fsps_pkg::REQ_QUERY |=> busy)
		else $error("query accepted but busy low");

	// the final count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |->
			result.hit_total <= fsps_pkg::CNT_W'(fsps_pkg::MAX_ENTRIES))
		else $error("hit total out of range");

endmodule
